// File: rtl/imt_pkg.sv
// Shared types and constants for the IMS to MIDI event translator.
// No dependencies; every other file of the block but imt_ram imports this package.
package imt_pkg;

  localparam int SYSEX_DEPTH = 32;
  localparam int CHANNELS    = 16;

  localparam int CH_W    = $clog2(CHANNELS);
  localparam int SX_AW   = $clog2(SYSEX_DEPTH);
  localparam int CNT_W   = $clog2(SYSEX_DEPTH + 1);
  localparam int STEP_W  = $clog2(SYSEX_DEPTH + 3);
  localparam int DELAY_W = 28;
  localparam int FACT_W  = 14;
  localparam int PROD_W  = 22;
  localparam int DIV_NW  = 34;
  localparam int DIV_DW  = PROD_W + 1;
  localparam int TEMPO_W = 24;
  localparam int CFG_AW  = 2;

  typedef logic [7:0] byte_t;

  localparam byte_t B_F0 = 8'hF0;
  localparam byte_t B_F7 = 8'hF7;
  localparam byte_t B_F8 = 8'hF8;
  localparam byte_t B_FC = 8'hFC;
  localparam byte_t B_FF = 8'hFF;
  localparam byte_t B_VEL_CC = 8'h27;
  localparam byte_t B_META_TEMPO = 8'h51;
  localparam byte_t B_META_END = 8'h2F;
  localparam byte_t B_TEMPO_LEN = 8'h03;
  localparam byte_t B_SX_TEMPO = 8'h7F;
  localparam logic [13:0] BEND_CENTER = 14'h1000;
  localparam logic [FACT_W-1:0] FACT_DEFAULT = 14'd128;
  localparam logic [DIV_NW-1:0] TEMPO_DIVIDEND = 34'd15360000000;

  localparam logic [3:0] K_NOTE_OFF = 4'h8;
  localparam logic [3:0] K_NOTE_ON  = 4'h9;
  localparam logic [3:0] K_VEL      = 4'hA;
  localparam logic [3:0] K_CTRL     = 4'hB;
  localparam logic [3:0] K_PROG     = 4'hC;
  localparam logic [3:0] K_BEND     = 4'hE;
  localparam logic [3:0] K_SYS      = 4'hF;

  localparam logic [CFG_AW-1:0] REG_TICKS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BPM   = 2'd1;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_VLQ, ACT_END, ACT_STATUS, ACT_VEL, ACT_PROG,
    ACT_RETRIG, ACT_NOTE, ACT_BEND, ACT_TEMPO, ACT_SYSEX
  } act_t;

  typedef struct packed {
    logic              take_byte;
    logic              decode;
    act_t              act;
    logic              add_tpb;
    logic              set_run;
    logic              clr_full;
    logic              set_first;
    logic              sx_clear;
    logic              sx_start;
    logic              sx_add;
    logic              div_start;
    logic              emit;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] step_nxt;
  } cmd_t;

  typedef struct packed {
    byte_t             b;
    byte_t             run;
    logic              tempo_hit;
    logic              slot_free;
    logic              div_done;
    logic [STEP_W-1:0] seq_start;
    logic [STEP_W-1:0] seq_last;
  } sts_t;

endpackage

// File: rtl/imt_if.sv
// Channel interfaces of the translator: input bytes, result bytes, register writes.
// Depends on imt_pkg.
interface imt_in_if;
  import imt_pkg::*;
  logic  valid;
  logic  ready;
  byte_t ims_byte;
  modport source (output valid, output ims_byte, input ready);
  modport sink   (input valid, input ims_byte, output ready);
endinterface

interface imt_out_if;
  import imt_pkg::*;
  logic  valid;
  logic  ready;
  byte_t midi_byte;
  logic  run_last;
  logic  sysex_truncated;
  logic  track_ended;
  modport source (output valid, output midi_byte, output run_last,
                  output sysex_truncated, output track_ended, input ready);
  modport sink   (input valid, input midi_byte, input run_last,
                  input sysex_truncated, input track_ended, output ready);
endinterface

interface imt_cfg_if;
  import imt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  byte_t             data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: rtl/imt_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module imt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/imt_div.sv
// Restoring divider, one quotient bit per cycle, for the tempo value.
// Depends on imt_pkg.
module imt_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [imt_pkg::DIV_NW-1:0] dividend,
  input  logic [imt_pkg::DIV_DW-1:0] divisor,
  output logic [imt_pkg::DIV_NW-1:0] quotient,
  output logic                     done
);
  import imt_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_DW+1:0] shifted;
  logic              fits;

  always_comb begin
    shifted  = {rem_r, quo_r[DIV_NW-1]};
    fits     = shifted >= {2'b00, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (DIV_DW + 1)'(shifted - {2'b00, divisor})
                     : shifted[DIV_DW:0];
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

// File: rtl/imt_ctrl.sv
// Controller: parse phase and byte sequencer; drives the datapath by command.
// Depends on imt_pkg.
module imt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  imt_pkg::sts_t sts,
  output imt_pkg::cmd_t cmd
);
  import imt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_START, S_DIV, S_EMIT} state_t;
  typedef enum logic [2:0] {
    PH_DELAY, PH_EVENT, PH_FIRST, PH_SECOND, PH_SYSEX, PH_DONE
  } phase_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  act_t              act_r, act_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              do_delay, do_first;

  always_comb begin
    cmd       = '0;
    cmd.act   = ACT_NONE;
    state_nxt = state_r;
    phase_nxt = phase_r;
    act_nxt   = act_r;
    step_nxt  = step_r;
    do_delay  = 1'b0;
    do_first  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (phase_r)
          PH_DELAY: do_delay = 1'b1;
          PH_EVENT: begin
            if (sts.b[7]) begin
              cmd.set_run = 1'b1;
              if (sts.b == B_F0) begin
                cmd.sx_clear = 1'b1;
                phase_nxt    = PH_SYSEX;
              end else if (sts.b == B_FC) begin
                cmd.act   = ACT_END;
                phase_nxt = PH_DONE;
              end else if (sts.b[7:4] == K_SYS) begin
                cmd.act   = ACT_STATUS;
                phase_nxt = PH_DELAY;
              end else begin
                cmd.act   = ACT_STATUS;
                phase_nxt = PH_FIRST;
              end
            end else begin
              cmd.clr_full = 1'b1;
              if (sts.run == B_F0) begin
                cmd.sx_start = 1'b1;
                phase_nxt    = PH_SYSEX;
              end else if (sts.run == B_FC) begin
                cmd.act   = ACT_END;
                phase_nxt = PH_DONE;
              end else if (!sts.run[7] || sts.run[7:4] == K_SYS) begin
                // no usable running event: treat as a delay byte
                do_delay = 1'b1;
              end else begin
                do_first = 1'b1;
              end
            end
          end
          PH_FIRST: do_first = 1'b1;
          PH_SECOND: begin
            phase_nxt = PH_DELAY;
            if (sts.run[7:4] == K_NOTE_OFF) begin
              cmd.act = ACT_RETRIG;
            end else if (sts.run[7:4] == K_NOTE_ON) begin
              cmd.act = ACT_NOTE;
            end else if (sts.run[7:4] == K_BEND) begin
              cmd.act = ACT_BEND;
            end
          end
          PH_SYSEX: begin
            if (sts.b == B_F7) begin
              cmd.act   = sts.tempo_hit ? ACT_TEMPO : ACT_SYSEX;
              phase_nxt = PH_DELAY;
            end else begin
              cmd.sx_add = 1'b1;
            end
          end
          PH_DONE: ;
          default: ;
        endcase
        if (do_delay) begin
          if (sts.b == B_F8) begin
            cmd.add_tpb = 1'b1;
            phase_nxt   = PH_DELAY;
          end else begin
            cmd.act   = ACT_VLQ;
            phase_nxt = PH_EVENT;
          end
        end
        if (do_first) begin
          if (sts.run[7:4] == K_VEL) begin
            cmd.act   = ACT_VEL;
            phase_nxt = PH_DELAY;
          end else if (sts.run[7:4] == K_PROG) begin
            cmd.act   = ACT_PROG;
            phase_nxt = PH_DELAY;
          end else begin
            cmd.set_first = 1'b1;
            phase_nxt     = PH_SECOND;
          end
        end
        act_nxt   = cmd.act;
        state_nxt = S_START;
      end
      S_START: begin
        step_nxt = sts.seq_start;
        if (act_r == ACT_NONE) begin
          state_nxt = S_IDLE;
        end else if (act_r == ACT_TEMPO) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (step_r == sts.seq_last) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.step     = step_r;
    cmd.step_nxt = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DELAY;
      act_r   <= ACT_NONE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule

// File: rtl/imt_dp.sv
// Datapath: event state, delay sum, note table, sysex store, tempo math, output register.
// Depends on imt_pkg, imt_ram and imt_div.
module imt_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imt_pkg::cmd_t             cmd,
  output imt_pkg::sts_t             sts,
  input  imt_pkg::byte_t            in_byte,
  input  logic                      cfg_we,
  input  logic [imt_pkg::CFG_AW-1:0] cfg_addr,
  input  imt_pkg::byte_t            cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output imt_pkg::byte_t            out_byte,
  output logic                      out_last,
  output logic                      out_cut,
  output logic                      out_end
);
  import imt_pkg::*;

  byte_t              tpb_r, bpm_r;
  byte_t              b_r, run_r, first_r, old_note_r;
  logic               full_r;
  logic [DELAY_W-1:0] sum_r, vlq_r;
  byte_t              note_r [CHANNELS];
  logic [CNT_W-1:0]   sx_cnt_r, sx_cnt_nxt, kept_r;
  byte_t              hd_r [4];
  logic               cut_r;
  act_t               act_r;
  logic [PROD_W-1:0]  p_r;
  logic               out_valid_r, out_last_r, out_cut_r, out_end_r;
  byte_t              out_byte_r;

  logic [CH_W-1:0]    ch;
  logic [DELAY_W:0]   sum_add;
  logic [DELAY_W-1:0] sum_sat;
  byte_t              addend;
  logic               sx_we;
  logic [CNT_W-1:0]   sx_widx;
  logic               sx_cut;
  logic [FACT_W-1:0]  fact, fact_eff;
  logic [DIV_NW-1:0]  quo;
  logic               div_done;
  logic [TEMPO_W-1:0] tempo;
  logic [STEP_W-1:0]  rd_idx, seq_start, seq_last;
  byte_t              ram_rdata, emit_byte;
  logic [1:0]         grp;
  logic [13:0]        bend;

  assign ch = run_r[CH_W-1:0];

  // delay accumulation saturates at the 28-bit VLQ limit
  assign addend  = cmd.add_tpb ? tpb_r : b_r;
  assign sum_add = {1'b0, sum_r} + (DELAY_W + 1)'(addend);
  assign sum_sat = sum_add[DELAY_W] ? '1 : sum_add[DELAY_W-1:0];

  always_comb begin
    sx_widx    = cmd.sx_start ? '0 : sx_cnt_r;
    sx_we      = cmd.sx_start || (cmd.sx_add && sx_cnt_r < CNT_W'(SYSEX_DEPTH));
    sx_cnt_nxt = sx_cnt_r;
    if (cmd.sx_clear) begin
      sx_cnt_nxt = '0;
    end else if (cmd.sx_start) begin
      sx_cnt_nxt = CNT_W'(1);
    end else if (sx_we) begin
      sx_cnt_nxt = sx_cnt_r + CNT_W'(1);
    end else if (cmd.decode && (cmd.act == ACT_SYSEX || cmd.act == ACT_TEMPO)) begin
      sx_cnt_nxt = '0;
    end
  end

  assign sx_cut = sx_cnt_r >= CNT_W'(SYSEX_DEPTH);
  assign fact = {(sx_cnt_r > CNT_W'(2)) ? hd_r[2][6:0] : 7'd0,
                 (sx_cnt_r > CNT_W'(3)) ? hd_r[3][6:0] : 7'd0};
  assign fact_eff = (fact == '0) ? FACT_DEFAULT : fact;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r    <= 8'd48;
      bpm_r    <= 8'd120;
      run_r    <= '0;
      full_r   <= 1'b0;
      first_r  <= '0;
      sum_r    <= '0;
      sx_cnt_r <= '0;
      act_r    <= ACT_NONE;
      for (int i = 0; i < CHANNELS; i++) begin
        note_r[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_addr == REG_TICKS) begin
        tpb_r <= cfg_data;
      end
      if (cfg_we && cfg_addr == REG_BPM) begin
        bpm_r <= cfg_data;
      end
      if (cmd.set_run) begin
        run_r  <= b_r;
        full_r <= 1'b1;
      end
      if (cmd.clr_full) begin
        full_r <= 1'b0;
      end
      if (cmd.set_first) begin
        first_r <= b_r;
      end
      if (cmd.add_tpb) begin
        sum_r <= sum_sat;
      end
      sx_cnt_r <= sx_cnt_nxt;
      if (cmd.decode) begin
        act_r <= cmd.act;
        unique case (cmd.act)
          ACT_VLQ:    sum_r <= '0;
          ACT_RETRIG: note_r[ch] <= first_r;
          ACT_NOTE:   note_r[ch] <= (b_r != '0) ? first_r : '0;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      b_r <= in_byte;
    end
    if (cmd.decode && cmd.act == ACT_VLQ) begin
      vlq_r <= sum_sat;
    end
    if (cmd.decode && cmd.act == ACT_RETRIG) begin
      old_note_r <= note_r[ch];
    end
    if (cmd.decode && (cmd.act == ACT_SYSEX || cmd.act == ACT_TEMPO)) begin
      cut_r  <= sx_cut;
      kept_r <= sx_cut ? CNT_W'(SYSEX_DEPTH - 1) : sx_cnt_r;
    end
    if (cmd.decode && cmd.act == ACT_TEMPO) begin
      p_r <= PROD_W'(bpm_r) * PROD_W'(fact_eff);
    end
    if (sx_we && sx_widx < CNT_W'(4)) begin
      hd_r[sx_widx[1:0]] <= b_r;
    end
  end

  assign rd_idx = cmd.step_nxt - STEP_W'(2);

  imt_ram #(.WIDTH(8), .DEPTH(SYSEX_DEPTH)) u_sx_ram (
    .clk   (clk),
    .we    (sx_we),
    .waddr (sx_widx[SX_AW-1:0]),
    .wdata (b_r),
    .raddr (rd_idx[SX_AW-1:0]),
    .rdata (ram_rdata)
  );

  imt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (TEMPO_DIVIDEND + DIV_NW'(p_r)),
    .divisor  ({p_r, 1'b0}),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    if (p_r < PROD_W'(128)) begin
      tempo = '0;
    end else if (quo[DIV_NW-1:TEMPO_W] != '0) begin
      tempo = '1;
    end else begin
      tempo = quo[TEMPO_W-1:0];
    end
  end

  // byte position range of each output sequence
  always_comb begin
    seq_start = '0;
    seq_last  = '0;
    unique case (act_r)
      ACT_VLQ: begin
        seq_last = STEP_W'(3);
        if (vlq_r[27:21] != '0) begin
          seq_start = STEP_W'(0);
        end else if (vlq_r[20:14] != '0) begin
          seq_start = STEP_W'(1);
        end else if (vlq_r[13:7] != '0) begin
          seq_start = STEP_W'(2);
        end else begin
          seq_start = STEP_W'(3);
        end
      end
      ACT_END:    seq_last = STEP_W'(2);
      ACT_VEL, ACT_NOTE, ACT_BEND: seq_last = STEP_W'(1);
      ACT_RETRIG: begin
        seq_start = full_r ? STEP_W'(1) : STEP_W'(0);
        seq_last  = STEP_W'(6);
      end
      ACT_TEMPO:  seq_last = STEP_W'(5);
      ACT_SYSEX: begin
        seq_start = full_r ? STEP_W'(0) : STEP_W'(1);
        seq_last  = STEP_W'(kept_r) + STEP_W'(2);
      end
      default: ;
    endcase
  end

  assign grp  = ~cmd.step[1:0];
  assign bend = ({b_r[6:0], first_r[6:0]} >> 1) + BEND_CENTER;

  always_comb begin
    emit_byte = '0;
    unique case (act_r)
      ACT_VLQ: begin
        unique case (grp)
          2'd3: emit_byte = {1'b1, vlq_r[27:21]};
          2'd2: emit_byte = {1'b1, vlq_r[20:14]};
          2'd1: emit_byte = {1'b1, vlq_r[13:7]};
          default: emit_byte = {1'b0, vlq_r[6:0]};
        endcase
      end
      ACT_END: begin
        if (cmd.step == STEP_W'(0)) begin
          emit_byte = B_FF;
        end else if (cmd.step == STEP_W'(1)) begin
          emit_byte = B_META_END;
        end
      end
      ACT_STATUS: emit_byte = (b_r[7:4] == K_VEL) ? {K_CTRL, b_r[3:0]} : b_r;
      ACT_VEL:    emit_byte = (cmd.step == STEP_W'(0)) ? B_VEL_CC : b_r;
      ACT_PROG:   emit_byte = b_r;
      ACT_RETRIG: begin
        unique case (cmd.step[2:0])
          3'd0: emit_byte = {K_NOTE_OFF, run_r[3:0]};
          3'd1: emit_byte = old_note_r;
          3'd4: emit_byte = {K_NOTE_ON, run_r[3:0]};
          3'd5: emit_byte = first_r;
          3'd6: emit_byte = (b_r != '0) ? b_r : 8'd1;
          default: emit_byte = '0;
        endcase
      end
      ACT_NOTE: emit_byte = (cmd.step == STEP_W'(0)) ? first_r : b_r;
      ACT_BEND: emit_byte = (cmd.step == STEP_W'(0)) ? {1'b0, bend[6:0]}
                                                      : {1'b0, bend[13:7]};
      ACT_TEMPO: begin
        unique case (cmd.step[2:0])
          3'd0: emit_byte = B_FF;
          3'd1: emit_byte = B_META_TEMPO;
          3'd2: emit_byte = B_TEMPO_LEN;
          3'd3: emit_byte = tempo[23:16];
          3'd4: emit_byte = tempo[15:8];
          default: emit_byte = tempo[7:0];
        endcase
      end
      ACT_SYSEX: begin
        if (cmd.step == STEP_W'(0)) begin
          emit_byte = B_F0;
        end else if (cmd.step == STEP_W'(1)) begin
          emit_byte = 8'(kept_r) + 8'd1;
        end else if (cmd.step == seq_last) begin
          emit_byte = B_F7;
        end else begin
          emit_byte = ram_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= (cmd.step == seq_last);
      out_cut_r  <= (act_r == ACT_SYSEX) && cut_r;
      out_end_r  <= (act_r == ACT_END);
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_cut   = out_cut_r;
  assign out_end   = out_end_r;

  assign sts.b         = b_r;
  assign sts.run       = run_r;
  assign sts.tempo_hit = (sx_cnt_r >= CNT_W'(2)) && (hd_r[0] == B_SX_TEMPO) &&
                         (hd_r[1] == '0);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.div_done  = div_done;
  assign sts.seq_start = seq_start;
  assign sts.seq_last  = seq_last;
endmodule

// File: rtl/ims_to_midi_event_translator_core.sv
// Top level of the IMS to MIDI event translator: controller plus datapath.
// Depends on imt_pkg, imt_if, imt_ctrl and imt_dp.
//
// One IMS byte is taken at a time. A byte that produces no MIDI byte passes
// through transfer, decode and sequence setup; a byte that produces MIDI bytes
// goes through the same steps and then sends them, one byte per cycle from the
// output register when the output side takes every byte at once. A tempo sysex
// also runs the bit-serial 34-step tempo divider before its bytes. The longest
// burst is a passed-through sysex of up to 34 bytes. Registers may be written
// at any time the block is idle; the configuration port is always ready.
module ims_to_midi_event_translator_core (
  input logic       clk,
  input logic       rst_n,
  imt_in_if.sink    in_ch,
  imt_out_if.source out_ch,
  imt_cfg_if.sink   cfg_ch
);
  import imt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  imt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  imt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_ch.ims_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_addr  (cfg_ch.addr),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.midi_byte),
    .out_last  (out_ch.run_last),
    .out_cut   (out_ch.sysex_truncated),
    .out_end   (out_ch.track_ended)
  );

  assign cfg_ch.ready = 1'b1;
endmodule

// File: rtl/imt_checker.sv
// Port-level checks of the translator, attached to the top level by bind.
// Depends on imt_pkg.
module imt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input imt_pkg::byte_t midi_byte,
  input logic           run_last
);
  import imt_pkg::*;

  // one byte in flight: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous byte in work");

  // a byte that is not the last of its run means the run is still going
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> !in_ready)
    else $error("input ready in the middle of a result run");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(midi_byte) && $stable(run_last))
    else $error("stalled result changed");
endmodule

bind ims_to_midi_event_translator_core imt_checker u_imt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .midi_byte (out_ch.midi_byte),
  .run_last  (out_ch.run_last)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IMS to MIDI event translator core.
// Depends on imt_pkg, the imt_if interfaces and the translator RTL.
module testbench;
  import imt_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  typedef enum int { PRS_DELAY, PRS_EVENT, PRS_FIRST, PRS_SECOND, PRS_SYSEX, PRS_DONE } prs_t;

  typedef struct {
    byte_t b;
    logic  last;
    logic  cut;
    logic  endt;
  } midi_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imt_in_if  in_if ();
  imt_out_if out_if ();
  imt_cfg_if cfg_if ();

  ims_to_midi_event_translator_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  always #4 clk = ~clk;

  // translator state mirror
  byte_t      m_ticks = 8'd48;
  byte_t      m_bpm = 8'd120;
  prs_t       m_phase = PRS_DELAY;
  byte_t      m_run = 8'h00;
  logic       m_full = 1'b0;
  byte_t      m_first = 8'h00;
  logic [27:0] m_delay = '0;
  byte_t      m_note [CHANNELS];
  byte_t      m_sx [SYSEX_DEPTH];
  int         m_sx_cnt = 0;
  logic       m_done = 1'b0;

  midi_res_t  step_out[$];
  midi_res_t  midi_expected[$];
  byte_t      ims_pending[$];
  int         errors = 0;
  int         cycles = 0;

  initial foreach (m_note[i]) m_note[i] = 8'h00;

  function automatic void emit(byte_t v, logic cut = 1'b0, logic endt = 1'b0);
    midi_res_t r;
    r.b = v; r.last = 1'b0; r.cut = cut; r.endt = endt;
    step_out.push_back(r);
  endfunction

  function automatic void add_ticks(int unsigned v);
    longint unsigned s;
    s = m_delay + v;
    m_delay = (s > 64'h0FFFFFFF) ? 28'hFFFFFFF : s[27:0];
  endfunction

  function automatic void take_delay(byte_t b);
    int groups;
    if (b == B_F8) begin
      add_ticks(m_ticks);
      return;
    end
    add_ticks(b);
    groups = 1;
    while (groups < 4 && (m_delay >> (7 * groups)) != 0) groups++;
    for (int g = groups - 1; g >= 0; g--)
      emit(byte_t'(((m_delay >> (7 * g)) & 28'h7F) | (g != 0 ? 8'h80 : 8'h00)));
    m_delay = '0;
    m_phase = PRS_EVENT;
  endfunction

  function automatic void end_track();
    emit(B_FF, 1'b0, 1'b1);
    emit(B_META_END, 1'b0, 1'b1);
    emit(8'h00, 1'b0, 1'b1);
    m_done = 1'b1;
    m_phase = PRS_DONE;
  endfunction

  function automatic logic [23:0] tempo_of(logic [13:0] f);
    longint unsigned p, q;
    p = longint'(m_bpm) * ((f == 0) ? 128 : f);
    if (p < 128) return 24'd0;
    q = (64'd15360000000 + p) / (2 * p);
    return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
  endfunction

  function automatic void sysex_close();
    logic [13:0] f;
    logic [23:0] t;
    logic        cut;
    int          kept;
    if (m_sx_cnt >= 2 && m_sx[0] == B_SX_TEMPO && m_sx[1] == 8'h00) begin
      f = '0;
      if (m_sx_cnt > 2) f[13:7] = m_sx[2][6:0];
      if (m_sx_cnt > 3) f[6:0] = m_sx[3][6:0];
      t = tempo_of(f);
      emit(B_FF); emit(B_META_TEMPO); emit(B_TEMPO_LEN);
      emit(t[23:16]); emit(t[15:8]); emit(t[7:0]);
    end else begin
      cut = (m_sx_cnt >= SYSEX_DEPTH);
      kept = cut ? SYSEX_DEPTH - 1 : m_sx_cnt;
      if (m_full) emit(B_F0, cut);
      emit(byte_t'(kept + 1), cut);
      for (int i = 0; i < kept; i++) emit(m_sx[i], cut);
      emit(B_F7, cut);
    end
    m_sx_cnt = 0;
    m_phase = PRS_DELAY;
  endfunction

  function automatic void sysex_push(byte_t b);
    if (m_sx_cnt < SYSEX_DEPTH) begin
      m_sx[m_sx_cnt] = b;
      m_sx_cnt++;
    end
  endfunction

  function automatic void first_data_byte(byte_t b);
    if (m_run[7:4] == K_VEL) begin
      emit(B_VEL_CC); emit(b);
      m_phase = PRS_DELAY;
    end else if (m_run[7:4] == K_PROG) begin
      emit(b);
      m_phase = PRS_DELAY;
    end else begin
      m_first = b;
      m_phase = PRS_SECOND;
    end
  endfunction

  function automatic void second_data_byte(byte_t b);
    logic [3:0]  ch;
    logic [13:0] v;
    ch = m_run[3:0];
    case (m_run[7:4])
      K_NOTE_OFF: begin
        if (!m_full) emit({K_NOTE_OFF, ch});
        emit(m_note[ch]); emit(8'h00); emit(8'h00);
        m_note[ch] = m_first;
        emit({K_NOTE_ON, ch}); emit(m_first); emit(b != 0 ? b : 8'h01);
      end
      K_NOTE_ON: begin
        m_note[ch] = (b != 0) ? m_first : 8'h00;
        emit(m_first); emit(b);
      end
      K_BEND: begin
        v = {b[6:0], m_first[6:0]};
        v = v / 2 + BEND_CENTER;
        emit({1'b0, v[6:0]}); emit({1'b0, v[13:7]});
      end
      default: ;
    endcase
    m_phase = PRS_DELAY;
  endfunction

  function automatic void status_or_data(byte_t b);
    if (b[7]) begin
      m_run = b;
      m_full = 1'b1;
      if (b == B_F0) begin
        m_sx_cnt = 0;
        m_phase = PRS_SYSEX;
      end else if (b == B_FC) begin
        end_track();
      end else if (b[7:4] == K_SYS) begin
        emit(b);
        m_phase = PRS_DELAY;
      end else begin
        emit(b[7:4] == K_VEL ? {K_CTRL, b[3:0]} : b);
        m_phase = PRS_FIRST;
      end
      return;
    end
    m_full = 1'b0;
    if (m_run == B_F0) begin
      m_sx_cnt = 0;
      sysex_push(b);
      m_phase = PRS_SYSEX;
    end else if (m_run == B_FC) begin
      end_track();
    end else if (!m_run[7] || m_run[7:4] == K_SYS) begin
      m_phase = PRS_DELAY;
      take_delay(b);
    end else begin
      first_data_byte(b);
    end
  endfunction

  // Work out the MIDI bytes one accepted IMS byte yields.
  function automatic void translate_byte(byte_t b);
    step_out.delete();
    if (m_done) return;
    case (m_phase)
      PRS_DELAY:  take_delay(b);
      PRS_EVENT:  status_or_data(b);
      PRS_FIRST:  first_data_byte(b);
      PRS_SECOND: second_data_byte(b);
      PRS_SYSEX:  if (b == B_F7) sysex_close(); else sysex_push(b);
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) midi_expected.push_back(step_out[i]);
  endfunction

  // ---------------- input driver ----------------
  logic in_took = 1'b0;
  int   in_gap = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) translate_byte(in_if.ims_byte);
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.ims_byte = 8'h00;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_took)) begin
      if (in_gap > 0 || ims_pending.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else begin
        in_if.ims_byte <= ims_pending.pop_front();
        in_if.valid <= 1'b1;
        in_gap <= pick_gap();
      end
    end
  end

  // ---------------- output monitor ----------------
  int out_stall = 0;
  initial out_if.ready = 1'b0;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    midi_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (midi_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected MIDI byte %h", $time, out_if.midi_byte);
      end else begin
        e = midi_expected.pop_front();
        if (out_if.midi_byte !== e.b || out_if.run_last !== e.last ||
            out_if.sysex_truncated !== e.cut || out_if.track_ended !== e.endt) begin
          errors++;
          $display("%0t: expected byte %h last %b cut %b end %b, got %h %b %b %b",
                   $time, e.b, e.last, e.cut, e.endt, out_if.midi_byte,
                   out_if.run_last, out_if.sysex_truncated, out_if.track_ended);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  byte_t gen_run = 8'h00;
  int    items_sent = 0;

  function automatic void queue_byte(byte_t b);
    ims_pending.push_back(b);
    items_sent++;
  endfunction

  function automatic byte_t not_f7();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255)); while (b == B_F7);
    return b;
  endfunction

  function automatic void sysex_body();
    int n;
    if ($urandom_range(0, 99) < 35) begin
      queue_byte(B_SX_TEMPO); queue_byte(8'h00);
      n = $urandom_range(0, 3);
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(SYSEX_DEPTH - 4, SYSEX_DEPTH + 8)
                                       : $urandom_range(0, 6);
    end
    repeat (n) queue_byte(not_f7());
    queue_byte(B_F7);
  endfunction

  // Queue one delay plus one event, with random status, running status or noise.
  function automatic void gen_event();
    byte_t st;
    int    r;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) queue_byte(B_F8);
    do st = byte_t'($urandom_range(0, 255)); while (st == B_F8);
    queue_byte(st);
    r = $urandom_range(0, 99);
    if (r < 25 && gen_run[7]) begin
      st = gen_run;
    end else begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3, 4, 5: st = {4'h8 + 4'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
        6, 7:   st = B_F0;
        default: begin
          do st = {K_SYS, 4'($urandom_range(0, 15))}; while (st == B_FC || st == B_F0);
        end
      endcase
      queue_byte(st);
      gen_run = st;
      if (st == B_F0) begin
        sysex_body();
        return;
      end
    end
    if (st == B_F0) begin
      queue_byte(not_f7());
      sysex_body();
    end else if (st[7:4] == K_VEL || st[7:4] == K_PROG) begin
      queue_byte(byte_t'($urandom_range(0, 255)));
    end else if (st[7:4] != K_SYS) begin
      queue_byte(byte_t'($urandom_range(0, 255)));
      queue_byte(byte_t'($urandom_range(0, 255)));
    end else if (r < 25) begin
      queue_byte(byte_t'($urandom_range(0, 255)));
    end
  endfunction

  task automatic wait_idle();
    while (ims_pending.size() != 0 || in_if.valid || midi_expected.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, byte_t v);
    @(negedge clk);
    cfg_if.addr <= idx;
    cfg_if.data <= v;
    cfg_if.valid <= 1'b1;
    #1;
    while (!cfg_if.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    if (idx == REG_TICKS) m_ticks = v; else m_bpm = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) gen_event();
  endtask

  initial begin
    byte_t directed[] = '{
      B_F8, B_F8, 8'h05, 8'h93, 8'h3C, 8'h40,   // note on
      8'h00, 8'h3C, 8'h00,                      // running note off
      8'h7F, 8'h81, 8'h3E, 8'h00,               // retrigger, zero velocity
      8'h00, 8'h45, 8'hFF,                      // running retrigger
      8'hFF, 8'hA3, 8'h7F, 8'h00, 8'hC5, 8'h80,
      8'h00, 8'hE2, 8'h7F, 8'h7F, 8'h00, 8'hE2, 8'h00, 8'h00,
      8'h00, 8'hB1, 8'h10, 8'h20, 8'h00, 8'hD4, 8'h01, 8'h02,
      8'h00, B_F0, B_SX_TEMPO, 8'h00, 8'h7F, 8'h7F, B_F7,
      8'h00, 8'hF0, 8'h11, 8'h22, B_F7,
      8'h00, 8'hF3, 8'h00, 8'h40                // system status, then running noise
    };
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) queue_byte(directed[i]);
    random_phase(14);
    wait_idle();
    write_reg(REG_TICKS, 8'd0);
    write_reg(REG_BPM, 8'd0);
    random_phase(12);
    wait_idle();
    write_reg(REG_TICKS, 8'd255);
    write_reg(REG_BPM, 8'd255);
    random_phase(14);
    wait_idle();
    write_reg(REG_TICKS, byte_t'($urandom_range(1, 254)));
    write_reg(REG_BPM, 8'd1);
    random_phase(10);
    // end of track, then bytes that must be ignored
    queue_byte(8'h00); queue_byte(B_FC);
    queue_byte(8'h00); queue_byte(8'h90);
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/imt_pkg.sv
rtl/imt_if.sv
rtl/imt_ram.sv
rtl/imt_div.sv
rtl/imt_ctrl.sv
rtl/imt_dp.sv
rtl/ims_to_midi_event_translator_core.sv
rtl/imt_checker.sv
tb/testbench.sv
